[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros used by the checker file mdu_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is held
`define MDU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mdu assertion failed");

// clocked property with its own message
`define MDU_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

[hdl/mdu_pkg.sv]
// ----------------------------------------------------------------------------
// mdu_pkg
// types and constants of the hi/lo multiply-divide unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdu_pkg;

    localparam int unsigned XLEN = 32;
    localparam int unsigned CNT_W = $clog2(XLEN);

    localparam logic [XLEN-1:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [XLEN-1:0] ALL_ONES = 32'hFFFF_FFFF;

    // operation codes
    typedef enum logic [2:0] {
        OP_MULT  = 3'd0,
        OP_MULTU = 3'd1,
        OP_DIV   = 3'd2,
        OP_DIVU  = 3'd3,
        OP_MTHI  = 3'd4,
        OP_MTLO  = 3'd5,
        OP_MFHI  = 3'd6,
        OP_MFLO  = 3'd7
    } t_op;

    typedef struct packed {
        t_op             req_type;
        logic [XLEN-1:0] operand_a;
        logic [XLEN-1:0] operand_b;
    } t_req;

    typedef struct packed {
        logic [XLEN-1:0] hi_out;
        logic [XLEN-1:0] lo_out;
        logic [XLEN-1:0] read_value;
        logic            div_by_zero;
    } t_rsp;

endpackage

[hdl/multiply_divide_unit_hi_lo.sv]
// ----------------------------------------------------------------------------
// multiply_divide_unit_hi_lo
// hi/lo multiply-divide unit: radix-2 shift-add multiply and restoring
// divide on one shared 34-bit adder, plus hi/lo moves
// ----------------------------------------------------------------------------
//  channel | valid   | ready   | payload
//  request | i_valid | o_ready | i_req  (req_type, operand_a, operand_b)
//  result  | o_valid | i_ready | o_rsp  (hi_out, lo_out, read_value, div_by_zero)
//
//  mult, multu, div, divu: 32 radix-2 iterations on the shared adder, then
//  one sign fix-up, which writes the result. divide by zero and moves: result
//  valid on the cycle after the transfer. o_ready is high only when idle and
//  no result is waiting, so a stalled result holds off the next transfer.
//  reset clears hi and lo to zero and drops o_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multiply_divide_unit_hi_lo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mdu_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output mdu_pkg::t_rsp o_rsp
);

    localparam int unsigned W = mdu_pkg::XLEN;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } t_state;

    t_state                      r_state, n_state;
    logic [mdu_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [W:0]                  r_acc_hi, n_acc_hi;
    logic [W-1:0]                r_acc_lo, n_acc_lo;
    logic [W-1:0]                r_opb, n_opb;
    logic                        r_is_div, n_is_div;
    logic                        r_neg_q, n_neg_q;
    logic                        r_neg_r, n_neg_r;
    logic [W-1:0]                r_hi, n_hi;
    logic [W-1:0]                r_lo, n_lo;
    logic                        r_out_valid, n_out_valid;
    mdu_pkg::t_rsp               r_out, n_out;

    logic                        in_xfer;
    logic                        op_signed;
    logic                        a_neg, b_neg;
    logic [W-1:0]                mag_a, mag_b;
    logic [W:0]                  shifted;
    logic [W+1:0]                add_x, add_y, unit_sum;
    logic                        add_cin;
    logic                        sub_ok;
    logic [2*W-1:0]              prod, prod_neg;

    assign o_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;
    assign in_xfer = i_valid && o_ready;

    // operand magnitudes for the signed forms
    assign op_signed = (i_req.req_type == mdu_pkg::OP_MULT) ||
                       (i_req.req_type == mdu_pkg::OP_DIV);
    assign a_neg = op_signed && i_req.operand_a[W-1];
    assign b_neg = op_signed && i_req.operand_b[W-1];
    assign mag_a = a_neg ? (~i_req.operand_a + W'(1)) : i_req.operand_a;
    assign mag_b = b_neg ? (~i_req.operand_b + W'(1)) : i_req.operand_b;

    // shared adder: trial subtract for divide, conditional add for multiply
    assign shifted = {r_acc_hi[W-1:0], r_acc_lo[W-1]};
    always_comb begin
        if (r_is_div) begin
            add_x   = {1'b0, shifted};
            add_y   = ~{2'b00, r_opb};
            add_cin = 1'b1;
        end else begin
            add_x   = {2'b00, r_acc_hi[W-1:0]};
            add_y   = r_acc_lo[0] ? {2'b00, r_opb} : '0;
            add_cin = 1'b0;
        end
    end
    assign unit_sum = add_x + add_y + {{(W+1){1'b0}}, add_cin};
    assign sub_ok   = !unit_sum[W+1];

    // product sign fix-up
    assign prod     = {r_acc_hi[W-1:0], r_acc_lo};
    assign prod_neg = ~prod + (2*W)'(1);

    // sequencer and next values
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_acc_hi    = r_acc_hi;
        n_acc_lo    = r_acc_lo;
        n_opb       = r_opb;
        n_is_div    = r_is_div;
        n_neg_q     = r_neg_q;
        n_neg_r     = r_neg_r;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // result transfer frees the output register
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cnt    = '1;
                    n_neg_r  = a_neg;
                    n_neg_q  = a_neg ^ b_neg;
                    n_acc_hi = '0;
                    n_out.read_value  = '0;
                    n_out.div_by_zero = 1'b0;
                    unique case (i_req.req_type) inside
                        mdu_pkg::OP_MULT, mdu_pkg::OP_MULTU: begin
                            n_is_div = 1'b0;
                            n_opb    = mag_a;
                            n_acc_lo = mag_b;
                            n_state  = S_RUN;
                        end
                        mdu_pkg::OP_DIV, mdu_pkg::OP_DIVU: begin
                            n_is_div = 1'b1;
                            n_opb    = mag_b;
                            n_acc_lo = mag_a;
                            if (i_req.operand_b == '0) begin
                                // divide by zero: direct result
                                n_hi = i_req.operand_a;
                                n_lo = a_neg ? W'(1) : mdu_pkg::ALL_ONES;
                                n_out.hi_out      = n_hi;
                                n_out.lo_out      = n_lo;
                                n_out.div_by_zero = 1'b1;
                                n_out_valid       = 1'b1;
                            end else begin
                                n_state = S_RUN;
                            end
                        end
                        mdu_pkg::OP_MTHI: begin
                            n_hi         = i_req.operand_a;
                            n_out.hi_out = i_req.operand_a;
                            n_out.lo_out = r_lo;
                            n_out_valid  = 1'b1;
                        end
                        mdu_pkg::OP_MTLO: begin
                            n_lo         = i_req.operand_a;
                            n_out.hi_out = r_hi;
                            n_out.lo_out = i_req.operand_a;
                            n_out_valid  = 1'b1;
                        end
                        mdu_pkg::OP_MFHI: begin
                            n_out.hi_out     = r_hi;
                            n_out.lo_out     = r_lo;
                            n_out.read_value = r_hi;
                            n_out_valid      = 1'b1;
                        end
                        default: begin
                            n_out.hi_out     = r_hi;
                            n_out.lo_out     = r_lo;
                            n_out.read_value = r_lo;
                            n_out_valid      = 1'b1;
                        end
                    endcase
                end
            end
            S_RUN: begin
                // one radix-2 step per cycle
                if (r_is_div) begin
                    n_acc_hi = sub_ok ? unit_sum[W:0] : shifted;
                    n_acc_lo = {r_acc_lo[W-2:0], sub_ok};
                end else begin
                    n_acc_hi = {1'b0, unit_sum[W:1]};
                    n_acc_lo = {unit_sum[0], r_acc_lo[W-1:1]};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                if (r_is_div) begin
                    n_lo = r_neg_q ? (~r_acc_lo + W'(1)) : r_acc_lo;
                    n_hi = r_neg_r ? (~r_acc_hi[W-1:0] + W'(1)) : r_acc_hi[W-1:0];
                end else begin
                    n_lo = r_neg_q ? prod_neg[W-1:0] : prod[W-1:0];
                    n_hi = r_neg_q ? prod_neg[2*W-1:W] : prod[2*W-1:W];
                end
                n_out.hi_out = n_hi;
                n_out.lo_out = n_lo;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, hi/lo and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_hi        <= '0;
            r_lo        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_hi        <= n_hi;
            r_lo        <= n_lo;
            r_out_valid <= n_out_valid;
        end
        r_acc_hi <= n_acc_hi;
        r_acc_lo <= n_acc_lo;
        r_opb    <= n_opb;
        r_is_div <= n_is_div;
        r_neg_q  <= n_neg_q;
        r_neg_r  <= n_neg_r;
        r_out    <= n_out;
    end

endmodule

[hdl/mdu_checker.sv]
// ----------------------------------------------------------------------------
// mdu_checker
// port-level checks of the hi/lo multiply-divide unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mdu_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input mdu_pkg::t_rsp o_rsp
);

    // stalled result holds
    `MDU_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_rsp))

    // no new request taken while a result waits
    `MDU_ASSERT(a_busy_out, i_clk, i_rst_n, !(o_valid && o_ready))

    // one request at a time
    `MDU_ASSERT(a_busy_in, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready)

    // divide by zero never comes with a read value
    `MDU_ASSERT_MSG(a_dz_read, i_clk, i_rst_n,
        o_valid && o_rsp.div_by_zero |-> o_rsp.read_value == '0, "dz with read value")

endmodule

bind multiply_divide_unit_hi_lo mdu_checker u_mdu_checker (.*);

[verif/multiply_divide_unit_hi_lo_test.sv]
// ----------------------------------------------------------------------------
// multiply_divide_unit_hi_lo_test
// self-checking bench for the hi/lo multiply-divide unit: a queue-fed driver
// sends directed corner cases, then random batches with and without idle
// cycles; a monitor compares every result with a cycle-free model of hi/lo
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multiply_divide_unit_hi_lo_test;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned TAIL_CYCLES  = 40;
    localparam int unsigned BATCHES      = 9;
    localparam int unsigned BATCH_ITEMS  = 100;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_ready;
    mdu_pkg::t_req  i_req   = '0;
    logic           o_valid;
    logic           i_ready = 1'b0;
    mdu_pkg::t_rsp  o_rsp;

    // model copy of the hi/lo pair
    logic [mdu_pkg::XLEN-1:0] model_hi = '0;
    logic [mdu_pkg::XLEN-1:0] model_lo = '0;

    mdu_pkg::t_req pend_q[$];
    mdu_pkg::t_rsp want_q[$];

    int idle_max   = 6;
    int send_gap   = 0;
    int recv_stall = 0;
    int idle_cyc   = 0;
    int mismatches = 0;
    int n_checked  = 0;
    int n_div_zero = 0;
    int n_overflow = 0;
    int op_seen[8];

    multiply_divide_unit_hi_lo uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // apply one request to the model and return the result it should give
    function automatic mdu_pkg::t_rsp hilo_update(input mdu_pkg::t_req rq);
        mdu_pkg::t_rsp            r;
        logic [63:0]              prod;
        logic [mdu_pkg::XLEN-1:0] a;
        logic [mdu_pkg::XLEN-1:0] b;
        logic [mdu_pkg::XLEN-1:0] ma;
        logic [mdu_pkg::XLEN-1:0] mb;
        logic [mdu_pkg::XLEN-1:0] q;
        logic [mdu_pkg::XLEN-1:0] rem;
        r = '0;
        a = rq.operand_a;
        b = rq.operand_b;
        case (rq.req_type)
            mdu_pkg::OP_MULT: begin
                prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                model_hi = prod[63:32];
                model_lo = prod[31:0];
            end
            mdu_pkg::OP_MULTU: begin
                prod = {32'd0, a} * {32'd0, b};
                model_hi = prod[63:32];
                model_lo = prod[31:0];
            end
            mdu_pkg::OP_DIV: begin
                if (b == '0) begin
                    model_lo = a[31] ? 32'd1 : mdu_pkg::ALL_ONES;
                    model_hi = a;
                    r.div_by_zero = 1'b1;
                    n_div_zero++;
                end else if (a == mdu_pkg::SIGN_BIT && b == mdu_pkg::ALL_ONES) begin
                    model_lo = mdu_pkg::SIGN_BIT;
                    model_hi = '0;
                    n_overflow++;
                end else begin
                    ma  = a[31] ? (32'd0 - a) : a;
                    mb  = b[31] ? (32'd0 - b) : b;
                    q   = ma / mb;
                    rem = ma % mb;
                    model_lo = (a[31] != b[31]) ? (32'd0 - q) : q;
                    model_hi = a[31] ? (32'd0 - rem) : rem;
                end
            end
            mdu_pkg::OP_DIVU: begin
                if (b == '0) begin
                    model_lo = mdu_pkg::ALL_ONES;
                    model_hi = a;
                    r.div_by_zero = 1'b1;
                    n_div_zero++;
                end else begin
                    model_lo = a / b;
                    model_hi = a % b;
                end
            end
            mdu_pkg::OP_MTHI: model_hi = a;
            mdu_pkg::OP_MTLO: model_lo = a;
            mdu_pkg::OP_MFHI: r.read_value = model_hi;
            default:          r.read_value = model_lo;
        endcase
        r.hi_out = model_hi;
        r.lo_out = model_lo;
        return r;
    endfunction

    // operand biased towards the awkward values
    function automatic logic [mdu_pkg::XLEN-1:0] pick_word();
        logic [mdu_pkg::XLEN-1:0] w;
        case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = 32'd1;
            2:       w = mdu_pkg::ALL_ONES;
            3:       w = mdu_pkg::SIGN_BIT;
            4:       w = 32'h7FFF_FFFF;
            5:       w = $urandom_range(0, 15);
            6:       w = 32'd0 - $urandom_range(1, 15);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic mdu_pkg::t_req random_req();
        mdu_pkg::t_req rq;
        int            sel;
        sel = $urandom_range(0, 99);
        if (sel < 12)      rq.req_type = mdu_pkg::OP_MULT;
        else if (sel < 24) rq.req_type = mdu_pkg::OP_MULTU;
        else if (sel < 42) rq.req_type = mdu_pkg::OP_DIV;
        else if (sel < 60) rq.req_type = mdu_pkg::OP_DIVU;
        else               rq.req_type = mdu_pkg::t_op'($urandom_range(4, 7));
        rq.operand_a = pick_word();
        rq.operand_b = pick_word();
        // occasional signed overflow divide
        if (rq.req_type == mdu_pkg::OP_DIV && $urandom_range(0, 19) == 0) begin
            rq.operand_a = mdu_pkg::SIGN_BIT;
            rq.operand_b = mdu_pkg::ALL_ONES;
        end
        return rq;
    endfunction

    task automatic queue_req(input mdu_pkg::t_op op, input logic [mdu_pkg::XLEN-1:0] a,
                             input logic [mdu_pkg::XLEN-1:0] b);
        mdu_pkg::t_req rq;
        rq.req_type  = op;
        rq.operand_a = a;
        rq.operand_b = b;
        pend_q.push_back(rq);
    endtask

    task automatic flag_mismatch(input string what, input logic [mdu_pkg::XLEN-1:0] got,
                                 input logic [mdu_pkg::XLEN-1:0] want);
        $display("%0t ns  %s: got %08h, want %08h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input mdu_pkg::t_rsp got);
        mdu_pkg::t_rsp want;
        if (want_q.size() == 0) begin
            flag_mismatch("result with nothing outstanding", got.hi_out, '0);
        end else begin
            want = want_q.pop_front();
            n_checked++;
            if (got.hi_out !== want.hi_out)
                flag_mismatch("hi_out", got.hi_out, want.hi_out);
            if (got.lo_out !== want.lo_out)
                flag_mismatch("lo_out", got.lo_out, want.lo_out);
            if (got.read_value !== want.read_value)
                flag_mismatch("read_value", got.read_value, want.read_value);
            if (got.div_by_zero !== want.div_by_zero)
                flag_mismatch("div_by_zero", {31'd0, got.div_by_zero},
                              {31'd0, want.div_by_zero});
        end
    endtask

    // request driver: one transfer per item, random gap before the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                want_q.push_back(hilo_update(i_req));
                op_seen[i_req.req_type]++;
                send_gap = $urandom_range(0, idle_max);
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    i_req   <= pend_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                check_result(o_rsp);
                recv_stall = $urandom_range(0, idle_max);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
    end

    initial begin
        wait (idle_cyc >= STALL_LIMIT);
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("multiply_divide_unit_hi_lo: mismatch");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases; reads straight after reset see zeros
        queue_req(mdu_pkg::OP_MFHI,  $urandom, $urandom);
        queue_req(mdu_pkg::OP_MFLO,  $urandom, $urandom);
        queue_req(mdu_pkg::OP_MULT,  mdu_pkg::SIGN_BIT, mdu_pkg::SIGN_BIT);
        queue_req(mdu_pkg::OP_MULT,  mdu_pkg::ALL_ONES, mdu_pkg::ALL_ONES);
        queue_req(mdu_pkg::OP_MULT,  32'h7FFF_FFFF, mdu_pkg::SIGN_BIT);
        queue_req(mdu_pkg::OP_MULTU, mdu_pkg::ALL_ONES, mdu_pkg::ALL_ONES);
        queue_req(mdu_pkg::OP_MULTU, '0, mdu_pkg::ALL_ONES);
        queue_req(mdu_pkg::OP_DIV,   32'd100, '0);
        queue_req(mdu_pkg::OP_DIV,   mdu_pkg::SIGN_BIT, '0);
        queue_req(mdu_pkg::OP_DIVU,  mdu_pkg::ALL_ONES, '0);
        queue_req(mdu_pkg::OP_DIV,   mdu_pkg::SIGN_BIT, mdu_pkg::ALL_ONES);
        queue_req(mdu_pkg::OP_DIV,   32'd0 - 32'd7, 32'd2);
        queue_req(mdu_pkg::OP_DIV,   32'd7, 32'd0 - 32'd2);
        queue_req(mdu_pkg::OP_DIV,   32'd0 - 32'd7, 32'd0 - 32'd2);
        queue_req(mdu_pkg::OP_DIVU,  mdu_pkg::ALL_ONES, 32'd1);
        queue_req(mdu_pkg::OP_DIVU,  32'd5, mdu_pkg::ALL_ONES);
        queue_req(mdu_pkg::OP_MTHI,  mdu_pkg::ALL_ONES, $urandom);
        queue_req(mdu_pkg::OP_MTLO,  mdu_pkg::SIGN_BIT, $urandom);
        queue_req(mdu_pkg::OP_MFHI,  $urandom, $urandom);
        queue_req(mdu_pkg::OP_MFLO,  $urandom, $urandom);
        queue_req(mdu_pkg::OP_MTHI,  '0, mdu_pkg::ALL_ONES);
        queue_req(mdu_pkg::OP_MTLO,  32'h7FFF_FFFF, mdu_pkg::ALL_ONES);
        queue_req(mdu_pkg::OP_MFHI,  mdu_pkg::ALL_ONES, mdu_pkg::ALL_ONES);
        queue_req(mdu_pkg::OP_MFLO,  '0, '0);

        // random batches, two of them with no idling on either side
        for (int bt = 0; bt < BATCHES; bt++) begin
            while (pend_q.size() != 0) @(negedge i_clk);
            idle_max = (bt == 2 || bt == 6) ? 0 : 6;
            for (int k = 0; k < BATCH_ITEMS; k++)
                pend_q.push_back(random_req());
        end

        // drain: everything sent, every result back, then a latency tail
        while (pend_q.size() != 0 || i_valid) @(negedge i_clk);
        while (want_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("checked %0d results: mult %0d multu %0d div %0d divu %0d",
                 n_checked, op_seen[mdu_pkg::OP_MULT], op_seen[mdu_pkg::OP_MULTU],
                 op_seen[mdu_pkg::OP_DIV], op_seen[mdu_pkg::OP_DIVU]);
        $display("moves mthi %0d mtlo %0d mfhi %0d mflo %0d, %s %0d, overflow %0d",
                 op_seen[mdu_pkg::OP_MTHI], op_seen[mdu_pkg::OP_MTLO],
                 op_seen[mdu_pkg::OP_MFHI], op_seen[mdu_pkg::OP_MFLO],
                 "zero divisors", n_div_zero, n_overflow);
        if (mismatches == 0) begin
            $display("multiply_divide_unit_hi_lo: match");
        end else begin
            $display("multiply_divide_unit_hi_lo: mismatch");
        end
        $finish;
    end

endmodule

[multiply_divide_unit_hi_lo.f]
+incdir+hdl
hdl/mdu_pkg.sv
hdl/multiply_divide_unit_hi_lo.sv
hdl/mdu_checker.sv
verif/multiply_divide_unit_hi_lo_test.sv
